### rtl/frp_pkg.sv
// Package for the framed packet receiver: parser phase codes, register
// indexes, configuration and result structs shared by the RTL modules.
// Depends on nothing.
`default_nettype none

package frp_pkg;

	// Widths of the item fields and registers.
	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned DataW  = 32;
	localparam int unsigned AddrW  = 4;

	// Reset values of the configuration registers.
	localparam logic             RstTwoByteLength = 1'b1;
	localparam logic [LenW-1:0]  RstMaxLength     = 16'd256;
	localparam logic [ByteW-1:0] RstStartCode     = 8'hCA;

	// Register indexes (byte address divided by four).
	typedef enum logic [1:0] {
		REG_TWO_BYTE_LENGTH = 2'd0,
		REG_MAX_LENGTH      = 2'd1,
		REG_START_CODE      = 2'd2,
		REG_UNUSED          = 2'd3
	} reg_idx_t;

	// Parser phases; codes 5 to 7 are not used and fall back to waiting.
	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_LENGTH = 3'd1,
		PH_OPCODE = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHECK  = 3'd4
	} phase_t;

	// Current configuration as seen by the parser.
	typedef struct packed {
		logic             two_byte_length;
		logic [LenW-1:0]  max_length;
		logic [ByteW-1:0] start_code;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic             payload_valid;
		logic [ByteW-1:0] payload_byte;
		logic [LenW-1:0]  payload_index;
		logic             frame_good;
		logic [ByteW-1:0] frame_opcode;
		logic [LenW-1:0]  frame_length;
	} result_t;

endpackage

`default_nettype wire

### rtl/frp_in_if.sv
// Input channel of the framed packet receiver: one received byte per item.
// Depends on frp_pkg.
`default_nettype none

interface frp_in_if
	import frp_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/frp_out_if.sv
// Result channel of the framed packet receiver: one result per input byte.
// Depends on frp_pkg.
`default_nettype none

interface frp_out_if
	import frp_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             payload_valid;
	logic [ByteW-1:0] payload_byte;
	logic [LenW-1:0]  payload_index;
	logic             frame_good;
	logic [ByteW-1:0] frame_opcode;
	logic [LenW-1:0]  frame_length;

	modport source (
		output valid, output payload_valid, output payload_byte, output payload_index,
		output frame_good, output frame_opcode, output frame_length, input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_byte, input payload_index,
		input frame_good, input frame_opcode, input frame_length, output ready
	);
endinterface

`default_nettype wire

### rtl/frp_cfg_regs.sv
// APB-style configuration registers of the framed packet receiver.
// Depends on frp_pkg.
`default_nettype none

module frp_cfg_regs
	import frp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_byte_length <= RstTwoByteLength;
			cfg_q.max_length      <= RstMaxLength;
			cfg_q.start_code      <= RstStartCode;
		end else if (wr_en) begin
			case (idx)
				REG_TWO_BYTE_LENGTH: cfg_q.two_byte_length <= pwdata[0];
				REG_MAX_LENGTH:      cfg_q.max_length      <= pwdata[LenW-1:0];
				REG_START_CODE:      cfg_q.start_code      <= pwdata[ByteW-1:0];
				default: ;
			endcase
		end
	end

	// Read back of the register values.
	always_comb begin
		prdata = '0;
		case (idx)
			REG_TWO_BYTE_LENGTH: prdata[0]          = cfg_q.two_byte_length;
			REG_MAX_LENGTH:      prdata[LenW-1:0]  = cfg_q.max_length;
			REG_START_CODE:      prdata[ByteW-1:0] = cfg_q.start_code;
			default:             prdata            = '0;
		endcase
	end
endmodule

`default_nettype wire

### rtl/frp_parser.sv
// Frame parser of the framed packet receiver: phase register, length,
// opcode, count and checksum state, and the result of the byte at hand.
// Depends on frp_pkg.
`default_nettype none

module frp_parser
	import frp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [ByteW-1:0] rx_byte,
	input  wire cfg_t             cfg,
	output result_t               res
);
	phase_t           phase_q, phase_d;
	logic [LenW-1:0]  length_acc_q, length_acc_d;
	logic             length_byte_seen_q, length_byte_seen_d;
	logic [ByteW-1:0] opcode_hold_q, opcode_hold_d;
	logic [LenW-1:0]  byte_count_q, byte_count_d;
	logic [ByteW-1:0] running_sum_q, running_sum_d;
	logic [LenW-1:0]  count_inc;

	assign count_inc = byte_count_q + 1'b1;

	// Next state and result for the byte at hand.
	always_comb begin
		phase_d            = phase_q;
		length_acc_d       = length_acc_q;
		length_byte_seen_d = length_byte_seen_q;
		opcode_hold_d      = opcode_hold_q;
		byte_count_d       = byte_count_q;
		running_sum_d      = running_sum_q;
		res                = '0;
		case (phase_q)
			PH_WAIT: begin
				if (rx_byte == cfg.start_code) begin
					phase_d            = PH_LENGTH;
					length_acc_d       = '0;
					length_byte_seen_d = 1'b0;
					running_sum_d      = '0;
					byte_count_d       = '0;
				end
			end
			PH_LENGTH: begin
				if (cfg.two_byte_length && !length_byte_seen_q) begin
					length_acc_d       = {rx_byte, {ByteW{1'b0}}};
					length_byte_seen_d = 1'b1;
				end else begin
					if (cfg.two_byte_length) begin
						length_acc_d = length_acc_q | {{(LenW-ByteW){1'b0}}, rx_byte};
					end else begin
						length_acc_d = {{(LenW-ByteW){1'b0}}, rx_byte};
					end
					length_byte_seen_d = 1'b0;
					byte_count_d       = '0;
					phase_d            = PH_OPCODE;
				end
			end
			PH_OPCODE: begin
				opcode_hold_d = rx_byte;
				phase_d       = PH_DATA;
			end
			PH_DATA: begin
				// A zero or oversized length drops the frame and eats the byte.
				if (byte_count_q >= length_acc_q || length_acc_q > cfg.max_length) begin
					phase_d = PH_WAIT;
				end else begin
					res.payload_valid = 1'b1;
					res.payload_byte  = rx_byte;
					res.payload_index = byte_count_q;
					running_sum_d     = running_sum_q + rx_byte;
					byte_count_d      = count_inc;
					if (count_inc == length_acc_q) begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				phase_d = PH_WAIT;
				if (running_sum_q == rx_byte) begin
					res.frame_good   = 1'b1;
					res.frame_opcode = opcode_hold_q;
					res.frame_length = length_acc_q;
				end
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	// Parser state, advanced once per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_WAIT;
			length_acc_q       <= '0;
			length_byte_seen_q <= 1'b0;
			opcode_hold_q      <= '0;
			byte_count_q       <= '0;
			running_sum_q      <= '0;
		end else if (step) begin
			phase_q            <= phase_d;
			length_acc_q       <= length_acc_d;
			length_byte_seen_q <= length_byte_seen_d;
			opcode_hold_q      <= opcode_hold_d;
			byte_count_q       <= byte_count_d;
			running_sum_q      <= running_sum_d;
		end
	end
endmodule

`default_nettype wire

### rtl/framed_packet_receiver_unit.sv
// Top level of the framed packet receiver: input register, parser, result
// register and configuration port.
// Depends on frp_pkg, frp_in_if, frp_out_if, frp_cfg_regs and frp_parser.
//
//   Channel  Dir  Handshake        Payload
//   rx_ch    in   valid / ready    rx_byte
//   res_ch   out  valid / ready    payload_valid .. frame_length
//   APB      in   psel & penable   two_byte_length, max_length, start_code
//
// Each byte waits in the input register, where the parser works on it,
// and then sits in the result register.
// One byte is accepted in every cycle while the result side takes results.
// When the result register is held, the input register is held behind it,
// and rx_ch.ready drops once both are full.
// Reset empties both registers, sets the parser to wait for a start byte
// and loads the register defaults.
`default_nettype none

module framed_packet_receiver_unit
	import frp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	frp_in_if.sink                rx_ch,
	frp_out_if.source             res_ch,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready
);
	cfg_t             cfg;
	result_t          res_comb;
	result_t          res_s2;
	logic             valid_s1, valid_s2;
	logic [ByteW-1:0] byte_s1;
	logic             adv_s2, adv_s1, step;

	frp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: the result register frees when empty or taken.
	assign adv_s2      = !valid_s2 || res_ch.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign step        = valid_s1 && adv_s2;
	assign rx_ch.ready = adv_s1;

	frp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= rx_ch.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && rx_ch.valid) begin
			byte_s1 <= rx_ch.rx_byte;
		end
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	// Result channel.
	assign res_ch.valid         = valid_s2;
	assign res_ch.payload_valid = res_s2.payload_valid;
	assign res_ch.payload_byte  = res_s2.payload_byte;
	assign res_ch.payload_index = res_s2.payload_index;
	assign res_ch.frame_good    = res_s2.frame_good;
	assign res_ch.frame_opcode  = res_s2.frame_opcode;
	assign res_ch.frame_length  = res_s2.frame_length;
endmodule

`default_nettype wire

### rtl/frp_checker.sv
// Port-level checker of the framed packet receiver, bound to the top level.
// Depends on frp_pkg and framed_packet_receiver_unit.
`default_nettype none

module frp_checker
	import frp_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic             payload_valid,
	input wire logic [ByteW-1:0] payload_byte,
	input wire logic [LenW-1:0]  payload_index,
	input wire logic             frame_good,
	input wire logic [ByteW-1:0] frame_opcode,
	input wire logic [LenW-1:0]  frame_length
);
	// A byte is either a payload byte or a checksum byte, never both.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(payload_valid && frame_good))
		else $error("result is both payload and frame good");

	// Fields of a payload result are zero when it is not a payload byte.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !payload_valid) |-> (payload_byte == '0 && payload_index == '0))
		else $error("payload fields not zero without payload");

	// A good frame always carries a nonzero length; otherwise fields are zero.
	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (frame_good ? (frame_length != '0)
			: (frame_length == '0 && frame_opcode == '0)))
		else $error("frame fields inconsistent with frame_good");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(payload_valid)
			&& $stable(payload_index) && $stable(frame_good) && $stable(frame_length)))
		else $error("stalled result changed");
endmodule

bind framed_packet_receiver_unit frp_checker u_frp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_ch.valid),
	.res_ready     (res_ch.ready),
	.payload_valid (res_ch.payload_valid),
	.payload_byte  (res_ch.payload_byte),
	.payload_index (res_ch.payload_index),
	.frame_good    (res_ch.frame_good),
	.frame_opcode  (res_ch.frame_opcode),
	.frame_length  (res_ch.frame_length)
);

`default_nettype wire
